/* design/mlcc_pkg.sv */
`default_nettype none

package mlcc_pkg;

    // input field widths
    localparam int OPCODE_W  = 2;
    localparam int ADC_W     = 10;
    localparam int SECONDS_W = 32;
    localparam int MILLIS_W  = 10;
    localparam int BATT_W    = 12;

    // output field widths
    localparam int KIND_W    = 1;
    localparam int CHUNK_W   = 3;
    localparam int SLOT_W    = 7;
    localparam int LEVEL_W   = 8;

    // stream packing
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = OPCODE_W;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = KIND_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - (CHUNK_W + SLOT_W + LEVEL_W + 1 + SECONDS_W
                                              + MILLIS_W + BATT_W + 1);

    // accumulator
    localparam int SUM_W = 26;

    // fewer readings than this flag the sample
    localparam int FEW_LIMIT = 10;

    // configuration register indexes
    localparam logic [0:0] CFG_ZERO_LEVEL = 1'd0;
    localparam logic [0:0] CFG_MAX_LEVEL  = 1'd1;

    localparam logic [ADC_W-1:0]   ZERO_LEVEL_RST = 10'd512;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 8'd255;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_READING = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_STOP    = 2'd3;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TRUNCATE = 1'b1;

endpackage

`default_nettype wire

/* design/mlcc_divider.sv */
`default_nettype none

module mlcc_divider #(
    parameter int DIVISOR_W = 15
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [mlcc_pkg::SUM_W-1:0]       dividend,
    input  wire  [DIVISOR_W-1:0]             divisor,
    output logic                             done,
    output logic [mlcc_pkg::SUM_W-1:0]       quotient
);
    import mlcc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle; the dividend shifts
    // out of the top of quo_reg while quotient bits shift in at the bottom
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = !diff[DIVISOR_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* design/mic_level_chunk_collector_top.sv */
// A reading, start or stop is registered and handled in ST_EXEC before the next beat is taken;
// a stop record is registered into the output register from ST_EXEC.
// A collect tick runs a 26-step shift-subtract divider: ST_EXEC starts it, ST_DIV waits
// for its done, and ST_FIN registers the record before the next beat is taken.
// One item at a time; output backpressure stalls only items that emit a record.
// Reset (rst_n, async, low): all collection state cleared, registers to defaults.
`default_nettype none

module mic_level_chunk_collector_top #(
    parameter int SLOTS_PER_CHUNK = 128,
    parameter int CHUNK_COUNT     = 8,
    parameter int COUNT_WIDTH     = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // adc_value[9:0], now_seconds[41:10], now_millis[51:42], battery_mv[63:52]
    input  wire  [mlcc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode[1:0]
    input  wire  [mlcc_pkg::IN_USER_W-1:0]       s_axis_tuser,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // chunk_index[2:0], slot_index[9:3], level[17:10], chunk_opened[18],
    // start_seconds[50:19], start_millis[60:51], battery_level[72:61],
    // few_readings[73], zero[79:74]
    output logic [mlcc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // record_kind[0]
    output logic [mlcc_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    // chunk_closed
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [0:0]                           cfg_index,
    input  wire  [mlcc_pkg::ADC_W-1:0]           cfg_data
);
    import mlcc_pkg::*;

    localparam int SW  = $clog2(SLOTS_PER_CHUNK);
    localparam int CW  = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int DVW = COUNT_WIDTH - 1;

    localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOTS_PER_CHUNK - 1);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNK_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [OPCODE_W-1:0]    op_reg, op_next;
    logic [ADC_W-1:0]       adc_reg, adc_next;
    logic [SECONDS_W-1:0]   secs_reg, secs_next;
    logic [MILLIS_W-1:0]    msec_reg, msec_next;
    logic [BATT_W-1:0]      batt_reg, batt_next;

    logic [ADC_W-1:0]       zero_reg, zero_next;
    logic [LEVEL_W-1:0]     max_reg, max_next;

    logic                   collecting_reg, collecting_next;
    logic                   window_open_reg, window_open_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SECONDS_W-1:0]   win_sec_reg, win_sec_next;
    logic [MILLIS_W-1:0]    win_ms_reg, win_ms_next;
    logic [SECONDS_W-1:0]   chunk_sec_reg, chunk_sec_next;
    logic [CW-1:0]          chunk_reg, chunk_next;
    logic [SW-1:0]          slot_reg, slot_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0]  m_kind_reg, m_kind_next;
    logic                   m_last_reg, m_last_next;

    logic                   in_accept;
    logic                   out_free;
    logic [ADC_W-1:0]       diff;
    logic [SUM_W-1:0]       base_sum;
    logic [COUNT_WIDTH-1:0] base_cnt;
    logic [SUM_W:0]         sum_ext;
    logic [SUM_W-1:0]       sum_sat;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [DVW-1:0]         half_cnt;
    logic [DVW-1:0]         divisor;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;
    logic [LEVEL_W-1:0]     level;
    logic                   opened;
    logic                   closed;
    logic                   few;
    logic [SECONDS_W-1:0]   rec_secs;
    logic [MILLIS_W-1:0]    rec_ms;
    logic [BATT_W-1:0]      rec_batt;
    logic [CW-1:0]          chunk_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // reading accumulate: |adc - zero| into a saturating sum
    assign diff     = (adc_reg >= zero_reg) ? adc_reg - zero_reg : zero_reg - adc_reg;
    assign base_sum = window_open_reg ? sum_reg : '0;
    assign base_cnt = window_open_reg ? count_reg : '0;
    assign sum_ext  = {1'b0, base_sum} + (SUM_W + 1)'(diff);
    assign sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign cnt_inc  = (base_cnt == '1) ? base_cnt : base_cnt + 1'b1;

    assign half_cnt = count_reg[COUNT_WIDTH-1:1];
    assign divisor  = (half_cnt == '0) ? DVW'(1) : half_cnt;

    mlcc_divider #(
        .DIVISOR_W (DVW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign level     = (quotient > SUM_W'(max_reg)) ? max_reg : quotient[LEVEL_W-1:0];
    assign opened    = (slot_reg == '0);
    assign closed    = (slot_reg == LAST_SLOT);
    assign few       = (count_reg < COUNT_WIDTH'(FEW_LIMIT));
    assign rec_secs  = opened ? win_sec_reg : (closed ? chunk_sec_reg : '0);
    assign rec_ms    = opened ? win_ms_reg : '0;
    assign rec_batt  = opened ? batt_reg : '0;
    assign chunk_inc = (chunk_reg == LAST_CHUNK) ? '0 : chunk_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        adc_next         = adc_reg;
        secs_next        = secs_reg;
        msec_next        = msec_reg;
        batt_next        = batt_reg;
        zero_next        = zero_reg;
        max_next         = max_reg;
        collecting_next  = collecting_reg;
        window_open_next = window_open_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        win_sec_next     = win_sec_reg;
        win_ms_next      = win_ms_reg;
        chunk_sec_next   = chunk_sec_reg;
        chunk_next       = chunk_reg;
        slot_next        = slot_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;
        m_kind_next      = m_kind_reg;
        m_last_next      = m_last_reg;
        div_start        = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ZERO_LEVEL: zero_next = cfg_data;
                CFG_MAX_LEVEL:  max_next  = cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = s_axis_tuser;
                    adc_next   = s_axis_tdata[9:0];
                    secs_next  = s_axis_tdata[41:10];
                    msec_next  = s_axis_tdata[51:42];
                    batt_next  = s_axis_tdata[63:52];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_READING:
                    begin
                        if (collecting_reg)
                        begin
                            if (!window_open_reg)
                            begin
                                win_sec_next     = secs_reg;
                                win_ms_next      = msec_reg;
                                window_open_next = 1'b1;
                            end
                            sum_next   = sum_sat;
                            count_next = cnt_inc;
                        end
                        state_next = ST_IDLE;
                    end
                    OP_TICK:
                    begin
                        if (collecting_reg && count_reg != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_START:
                    begin
                        collecting_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    OP_STOP:
                    begin
                        if (!collecting_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            m_valid_next     = 1'b1;
                            m_kind_next      = KIND_TRUNCATE;
                            m_last_next      = 1'b0;
                            m_data_next      = {OUT_PAD_W'(0), 1'b0, BATT_W'(0), MILLIS_W'(0),
                                                SECONDS_W'(0), 1'b0, LEVEL_W'(slot_reg),
                                                SLOT_W'(LAST_SLOT), CHUNK_W'(chunk_reg)};
                            window_open_next = 1'b0;
                            sum_next         = '0;
                            count_next       = '0;
                            chunk_next       = chunk_inc;
                            slot_next        = '0;
                            collecting_next  = 1'b0;
                            state_next       = ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next     = 1'b1;
                    m_kind_next      = KIND_SAMPLE;
                    m_last_next      = closed;
                    m_data_next      = {OUT_PAD_W'(0), few, rec_batt, rec_ms, rec_secs, opened,
                                        level, SLOT_W'(slot_reg), CHUNK_W'(chunk_reg)};
                    count_next       = '0;
                    sum_next         = '0;
                    window_open_next = 1'b0;
                    if (opened)
                    begin
                        chunk_sec_next = win_sec_reg;
                    end
                    if (closed)
                    begin
                        chunk_next = chunk_inc;
                        slot_next  = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            zero_reg        <= ZERO_LEVEL_RST;
            max_reg         <= MAX_LEVEL_RST;
            collecting_reg  <= 1'b0;
            window_open_reg <= 1'b0;
            count_reg       <= '0;
            sum_reg         <= '0;
            win_sec_reg     <= '0;
            win_ms_reg      <= '0;
            chunk_sec_reg   <= '0;
            chunk_reg       <= '0;
            slot_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            zero_reg        <= zero_next;
            max_reg         <= max_next;
            collecting_reg  <= collecting_next;
            window_open_reg <= window_open_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            win_sec_reg     <= win_sec_next;
            win_ms_reg      <= win_ms_next;
            chunk_sec_reg   <= chunk_sec_next;
            chunk_reg       <= chunk_next;
            slot_reg        <= slot_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        adc_reg    <= adc_next;
        secs_reg   <= secs_next;
        msec_reg   <= msec_next;
        batt_reg   <= batt_next;
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire
